@@ hw/rtl/mt64_pkg.sv @@
// Constants and tempering function for the 64-bit Mersenne Twister generator.
package mt64_pkg;

   // State array geometry
   localparam int StateWords  = 312;
   localparam int ShiftOffset = 156;
   localparam int IdxWidth    = $clog2(StateWords + 1);

   localparam logic [IdxWidth-1:0] LastIdx   = IdxWidth'(StateWords - 1);
   localparam logic [IdxWidth-1:0] OffsetIdx = IdxWidth'(ShiftOffset);

   // Seeding recurrence multiplier, split into 32-bit halves
   localparam logic [63:0] InitMult   = 64'd6364136223846793005;
   localparam logic [31:0] InitMultLo = InitMult[31:0];
   localparam logic [31:0] InitMultHi = InitMult[63:32];

   // Twist and temper constants
   localparam logic [63:0] TwistMatrix = 64'hB5026F5AA96619E9;
   localparam logic [63:0] TemperB     = 64'h5555555555555555;
   localparam logic [63:0] TemperC     = 64'h71D67FFFEDA60000;
   localparam logic [63:0] TemperD     = 64'hFFF7EEE000000000;

   typedef logic [IdxWidth-1:0] idx_type;
   typedef logic [63:0]         word_type;

   // Output tempering: shifts, masks and xors only
   function automatic word_type temper(input word_type y_in);
      word_type y;
      y = y_in;
      y = y ^ ((y >> 29) & TemperB);
      y = y ^ ((y << 17) & TemperC);
      y = y ^ ((y << 37) & TemperD);
      y = y ^ (y >> 43);
      return y;
   endfunction

endpackage

@@ hw/rtl/mt19937_64_generator_top.sv @@
// MT19937-64 generator: state memory, lazy per-draw twist, multi-cycle reseed.
//
//  Channel   Ports                                   Direction  Transfer
//  request   start, busy, req_type, req_seed_value   in         start & !busy
//  result    rsp_strobe, rsp_random_word             out        rsp_strobe (one cycle)
//
// A draw runs through two memory read rounds (word i with word i+156, then
// word i+1) and one twist/temper/write-back state; the result strobes the cycle after.
// A reseed writes word 0 and then one 64x64 low product per further word, done as
// three 32x32 partial products registered in one state and summed in the next.
// busy is high while an item is in progress; start is ignored then.
// Reset clears the control state only; the state memory is undefined until a reseed.
// The result side cannot stall: rsp_strobe lasts exactly one cycle.
module mt19937_64_generator_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_type,
   input  mt64_pkg::word_type  req_seed_value,
   output logic                rsp_strobe,
   output mt64_pkg::word_type  rsp_random_word
);
   import mt64_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_DRAW_RD2  = 3'd1;
   localparam logic [2:0] ST_DRAW_CALC = 3'd2;
   localparam logic [2:0] ST_SEED_MUL  = 3'd3;
   localparam logic [2:0] ST_SEED_ADD  = 3'd4;

   localparam logic REQ_DRAW = 1'b0;

   // State memory, read data registered
   word_type state_mem [StateWords];
   word_type rd_a_ff, rd_b_ff;
   idx_type  rd_addr_a, rd_addr_b, wr_addr;
   logic     wr_en;
   word_type wr_data;

   logic [2:0]  state_ff, state_in;
   idx_type     idx_ff, idx_in;
   idx_type     cnt_ff, cnt_in;
   word_type    prev_ff, prev_in;
   word_type    word_ff, word_in;
   word_type    mid_ff, mid_in;
   word_type    pll_ff, pll_in;
   logic [31:0] phl_ff, phl_in;
   logic [31:0] plh_ff, plh_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   word_type    rsp_word_ff, rsp_word_in;

   idx_type  idx_p1, idx_p156, idx_next;
   word_type twist_y, twist_word, seed_x, seed_word;

   // Neighbor addresses around the read index
   assign idx_p1   = (idx_ff == LastIdx) ? '0 : idx_ff + 1'b1;
   assign idx_p156 = (idx_ff >= OffsetIdx) ? idx_ff - OffsetIdx : idx_ff + OffsetIdx;
   assign idx_next = idx_p1;

   // Twist of word i: upper 33 bits of word i, lower 31 bits of word i+1
   assign twist_y    = {word_ff[63:31], rd_a_ff[30:0]};
   assign twist_word = mid_ff ^ (twist_y >> 1) ^ (twist_y[0] ? TwistMatrix : '0);

   // Seeding recurrence: operand and sum of partial products
   assign seed_x    = prev_ff ^ (prev_ff >> 62);
   assign seed_word = pll_ff + {phl_ff + plh_ff, 32'd0}
                      + {{(64 - IdxWidth){1'b0}}, cnt_ff};

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_random_word = rsp_word_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      prev_in       = prev_ff;
      word_in       = word_ff;
      mid_in        = mid_ff;
      pll_in        = pll_ff;
      phl_in        = phl_ff;
      plh_in        = plh_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      rd_addr_a     = idx_ff;
      rd_addr_b     = idx_p156;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = twist_word;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_type == REQ_DRAW) begin
                  state_in = ST_DRAW_RD2;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = req_seed_value;
                  prev_in  = req_seed_value;
                  cnt_in   = idx_type'(1);
                  state_in = ST_SEED_MUL;
               end
            end
         end
         ST_DRAW_RD2: begin
            rd_addr_a = idx_p1;
            word_in   = rd_a_ff;
            mid_in    = rd_b_ff;
            state_in  = ST_DRAW_CALC;
         end
         ST_DRAW_CALC: begin
            wr_en         = 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_word_in   = temper(twist_word);
            idx_in        = idx_next;
            state_in      = ST_IDLE;
         end
         ST_SEED_MUL: begin
            // low x low keeps the full product; the cross terms only their low half
            pll_in   = word_type'(seed_x[31:0]) * word_type'(InitMultLo);
            phl_in   = seed_x[63:32] * InitMultLo;
            plh_in   = seed_x[31:0] * InitMultHi;
            state_in = ST_SEED_ADD;
         end
         ST_SEED_ADD: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = seed_word;
            prev_in = seed_word;
            if (cnt_ff == LastIdx) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_SEED_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= state_mem[rd_addr_a];
      rd_b_ff <= state_mem[rd_addr_b];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      prev_ff     <= prev_in;
      word_ff     <= word_in;
      mid_ff      <= mid_in;
      pll_ff      <= pll_in;
      phl_ff      <= phl_in;
      plh_ff      <= plh_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Checks
   a_strobe_from_calc: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_DRAW_CALC))
      else $error("result strobe without a twist cycle");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LastIdx)
      else $error("read index beyond state array");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not raise busy");

   a_seed_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEED_MUL || state_ff == ST_SEED_ADD)
         |-> (cnt_ff != '0 && cnt_ff <= LastIdx))
      else $error("seed counter out of range");

endmodule

@@ tb/sv/tb_mt19937_64_generator_top.sv @@
// Self-checking testbench for the MT19937-64 generator top level.
`timescale 1ns / 100ps

module tb_mt19937_64_generator_top;

   import mt64_pkg::word_type;

   // Generator geometry and constants, kept local to the predictor
   localparam int       NumWords    = 312;
   localparam int       MidOffset   = 156;
   localparam int       UnseededPos = 313;
   localparam word_type SeedMul     = 64'd6364136223846793005;
   localparam word_type MatrixA     = 64'hB5026F5AA96619E9;
   localparam word_type HiMask      = 64'hFFFFFFFF80000000;
   localparam word_type LoMask      = 64'h000000007FFFFFFF;
   localparam word_type MaskB       = 64'h5555555555555555;
   localparam word_type MaskC       = 64'h71D67FFFEDA60000;
   localparam word_type MaskD       = 64'hFFF7EEE000000000;

   localparam int RandomItems = 1500;
   localparam int DrainLimit  = 20000;
   localparam int TailCycles  = 50;
   localparam int PrintCap    = 20;

   typedef enum logic {
      CMD_DRAW   = 1'b0,
      CMD_RESEED = 1'b1
   } cmd_kind_type;

   typedef struct {
      cmd_kind_type kind;
      word_type     seed;
      int unsigned  idle_pct;   // chance per cycle that the sender holds off
      bit           drain;      // wait for all outstanding words before sending
   } gen_cmd_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   logic     busy;
   logic     req_type = 1'b0;
   word_type req_seed_value = '0;
   logic     rsp_strobe;
   word_type rsp_random_word;

   gen_cmd_type pending_cmds[$];
   word_type    expected_words[$];
   int unsigned cmd_total      = 0;
   int unsigned accepted_count = 0;
   int unsigned fail_count     = 0;

   // Predictor state
   word_type    mt_words[NumWords];
   int unsigned mt_pos = UnseededPos;

   mt19937_64_generator_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_seed_value  (req_seed_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_random_word (rsp_random_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Fill the state from a seed; next draw twists first
   function automatic void seed_words(input word_type seed);
      word_type prev;
      mt_words[0] = seed;
      for (int i = 1; i < NumWords; i++) begin
         prev        = mt_words[i-1];
         mt_words[i] = SeedMul * (prev ^ (prev >> 62)) + word_type'(i);
      end
      mt_pos = NumWords;
   endfunction

   // Full in-place twist of all words
   function automatic void twist_words();
      word_type y;
      word_type mag;
      for (int i = 0; i < NumWords; i++) begin
         y           = (mt_words[i] & HiMask) | (mt_words[(i + 1) % NumWords] & LoMask);
         mag         = y[0] ? MatrixA : '0;
         mt_words[i] = mt_words[(i + MidOffset) % NumWords] ^ (y >> 1) ^ mag;
      end
      mt_pos = 0;
   endfunction

   function automatic word_type tempered_word(input word_type raw);
      word_type y;
      y = raw;
      y = y ^ ((y >> 29) & MaskB);
      y = y ^ ((y << 17) & MaskC);
      y = y ^ ((y << 37) & MaskD);
      y = y ^ (y >> 43);
      return y;
   endfunction

   function automatic word_type draw_word();
      word_type raw;
      if (mt_pos >= NumWords)
         twist_words();
      raw    = mt_words[mt_pos % NumWords];
      mt_pos = mt_pos + 1;
      return tempered_word(raw);
   endfunction

   function automatic void push_cmd(input cmd_kind_type kind, input word_type seed,
                                    input int unsigned idle_pct, input bit drain);
      gen_cmd_type c;
      c.kind     = kind;
      c.seed     = seed;
      c.idle_pct = idle_pct;
      c.drain    = drain;
      pending_cmds.push_back(c);
      cmd_total++;
   endfunction

   function automatic word_type random_seed();
      word_type s;
      case ($urandom_range(7))
         0:       s = '0;
         1:       s = '1;
         2:       s = word_type'(1) << $urandom_range(63);
         default: s = {$urandom, $urandom};
      endcase
      return s;
   endfunction

   // Driver: predict on each transfer, then present the next queued item
   always @(posedge clock) begin : drive_requests
      gen_cmd_type c;
      logic        next_start;
      if (reset) begin
         start <= 1'b0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            if (cmd_kind_type'(req_type) == CMD_RESEED)
               seed_words(req_seed_value);
            else
               expected_words.push_back(draw_word());
            accepted_count++;
            next_start = 1'b0;
         end
         if (!next_start && pending_cmds.size() != 0) begin
            c = pending_cmds[0];
            if (!(c.drain && expected_words.size() != 0) &&
                $urandom_range(99) >= c.idle_pct) begin
               void'(pending_cmds.pop_front());
               req_type       <= c.kind;
               req_seed_value <= c.seed;
               next_start = 1'b1;
            end
         end
         start <= next_start;
      end
   end

   // Monitor: every strobe is one transfer, checked against the oldest prediction
   always @(posedge clock) begin : check_words
      word_type want;
      if (!reset && rsp_strobe) begin
         if (expected_words.size() == 0) begin
            fail_count++;
            if (fail_count <= PrintCap)
               $display("%0t: unexpected random_word: expected none, actual %h",
                        $time, rsp_random_word);
         end else begin
            want = expected_words.pop_front();
            if (rsp_random_word !== want) begin
               fail_count++;
               if (fail_count <= PrintCap)
                  $display("%0t: random_word mismatch: expected %h, actual %h",
                           $time, want, rsp_random_word);
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin : run_control
      int unsigned run_no;
      int unsigned run_len;
      int unsigned pct;
      int unsigned waited;

      // Directed: seed extremes, ignored seed on draws, reseed over reseed,
      // reseed in the middle of a stream
      push_cmd(CMD_RESEED, '0, 0, 1'b0);
      push_cmd(CMD_DRAW, '0, 0, 1'b0);
      push_cmd(CMD_DRAW, '1, 0, 1'b0);
      push_cmd(CMD_DRAW, 64'hA5A5_5A5A_F0F0_0F0F, 0, 1'b0);
      push_cmd(CMD_RESEED, '1, 0, 1'b0);
      push_cmd(CMD_DRAW, '1, 0, 1'b0);
      push_cmd(CMD_DRAW, '0, 0, 1'b0);
      push_cmd(CMD_RESEED, 64'd5489, 0, 1'b1);
      push_cmd(CMD_DRAW, '0, 0, 1'b0);
      push_cmd(CMD_DRAW, '0, 0, 1'b0);
      push_cmd(CMD_RESEED, 64'h8000_0000_0000_0000, 0, 1'b0);
      push_cmd(CMD_RESEED, 64'h1, 0, 1'b0);
      push_cmd(CMD_DRAW, '0, 0, 1'b0);
      push_cmd(CMD_RESEED, {$urandom, $urandom}, 0, 1'b0);
      push_cmd(CMD_DRAW, {$urandom, $urandom}, 0, 1'b0);
      push_cmd(CMD_RESEED, 64'h5555_5555_5555_5555, 0, 1'b0);
      push_cmd(CMD_DRAW, '0, 0, 1'b0);
      push_cmd(CMD_DRAW, '1, 0, 1'b0);

      // Random: runs of reseed then draws; some runs cross the twist point
      run_no = 0;
      while (cmd_total < RandomItems + 18) begin
         case (run_no % 3)
            0:       pct = 0;
            1:       pct = 86;
            default: pct = 30;
         endcase
         push_cmd(CMD_RESEED, random_seed(), pct, run_no % 2 == 0);
         if ($urandom_range(3) == 0)
            run_len = $urandom_range(700, 312);
         else
            run_len = $urandom_range(60, 0);
         // keep the total close to the planned item count
         if (cmd_total + run_len > RandomItems + 18)
            run_len = RandomItems + 18 - cmd_total;
         for (int i = 0; i < run_len; i++)
            push_cmd(CMD_DRAW, {$urandom, $urandom}, pct, 1'b0);
         run_no++;
      end
      // end on a draw so the tail wait covers the last item
      push_cmd(CMD_DRAW, {$urandom, $urandom}, 0, 1'b0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      wait (accepted_count == cmd_total);
      waited = 0;
      while (expected_words.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      if (expected_words.size() != 0) begin
         fail_count++;
         $display("%0t: %0d random_word results missing: expected %h, actual none",
                  $time, expected_words.size(), expected_words[0]);
      end
      repeat (TailCycles) @(posedge clock);

      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #50_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
